>>> rtl/core/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

	localparam int PAGE_W  = 20;
	localparam int ORDER_W = 4;
	localparam int LEVEL_W = 5;
	localparam int VAL_W   = 5;
	localparam int STAT_W  = 2;
	localparam int REQ_W   = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SIZE  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_START = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_ADDR = 2'd2;

	// node marker for an allocated node (-1 in five bits)
	localparam logic [VAL_W-1:0] NODE_TAKEN = 5'd31;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [ORDER_W-1:0] alloc_order;
		logic [PAGE_W-1:0]  page_number;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [PAGE_W-1:0]  block_page;
		logic [LEVEL_W-1:0] block_order;
	} rsp_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ACCEPT,
		OP_BEGIN_ALLOC,
		OP_BEGIN_WALK,
		OP_ERR_SPACE,
		OP_ERR_ADDR,
		OP_MARK_ROOT,
		OP_READ_LEFT,
		OP_READ_RIGHT,
		OP_PICK,
		OP_WALK_UP,
		OP_FOUND,
		OP_CLIMB,
		OP_LOAD_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic is_free;
		logic in_range;
		logic root_fits;
		logic at_order;
		logic next_at_order;
		logic node_root;
		logic parent_root;
		logic rd_taken;
		logic clear_last;
	} dp_stat_t;

	// ordering key: taken (-1) maps below every free order
	function automatic logic [VAL_W-1:0] node_key(input logic [VAL_W-1:0] v);
		return v + VAL_W'(1);
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/buddy_page_allocator.sv
`default_nettype none

// channel   direction  handshake            payload
// in        input      in_valid / in_stall  in_data   (bpa_pkg::req_t)
// out       output     out_valid/ out_stall out_data  (bpa_pkg::rsp_t)
// cfg       input      cfg_wr_en            cfg_wr_data (base_page)
//
// one item at a time; the tree lives in a single ram, one write and one read a cycle
// allocate walks down from the root, reading both children of each level to pick one,
//   then climbs back to the root updating each parent
// free and queries walk up from the leaf to the block; free goes on to the root, merging
// after reset the tree is swept to its free state node by node, in_stall high
// a finished result waits in the output register; the next item is taken meanwhile and
//   only its own result waits for out_stall to drop

module buddy_page_allocator #(
	parameter int POOL_ORDER = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire bpa_pkg::req_t               in_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output bpa_pkg::rsp_t                    out_data,
	input  wire logic                        cfg_wr_en,
	input  wire logic [bpa_pkg::PAGE_W-1:0]  cfg_wr_data
);

	bpa_pkg::dp_cmd_t  cmd;
	bpa_pkg::dp_stat_t st;

	// sequencer: walks down for allocate, up for free and queries
	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// node registers, tree ram, base register and result register
	bpa_datapath #(
		.POOL_ORDER (POOL_ORDER)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_data    (out_data)
	);

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == bpa_pkg::OP_LOAD_OUT) |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");

	// an accepted item makes the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again without processing");

	// failed requests carry no block
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != bpa_pkg::ST_OK) |->
		(out_data.block_page == '0 && out_data.block_order == '0))
		else $error("error result with nonzero block fields");

endmodule

`default_nettype wire

>>> rtl/core/bpa_ram.sv
`default_nettype none

module bpa_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 2047
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/bpa_datapath.sv
`default_nettype none

module bpa_datapath #(
	parameter int POOL_ORDER = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bpa_pkg::dp_cmd_t   cmd,
	output bpa_pkg::dp_stat_t       st,
	input  wire bpa_pkg::req_t      in_data,
	input  wire logic               cfg_wr_en,
	input  wire logic [bpa_pkg::PAGE_W-1:0] cfg_wr_data,
	output bpa_pkg::rsp_t           out_data
);

	localparam int NW    = POOL_ORDER + 1;
	localparam int NODES = (1 << NW) - 1;
	localparam int PW    = bpa_pkg::PAGE_W;
	localparam int LW    = bpa_pkg::LEVEL_W;
	localparam int VW    = bpa_pkg::VAL_W;
	localparam logic [NW-1:0] LEAF_BASE = NW'((1 << POOL_ORDER) - 1);
	localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
	localparam logic [LW-1:0] FULL_LVL  = LW'(POOL_ORDER);

	function automatic logic [NW-1:0] sibling_of(input logic [NW-1:0] n);
		return n[0] ? n + NW'(1) : n - NW'(1);
	endfunction

	logic [PW-1:0]      base_q;
	bpa_pkg::req_t      req_q;
	logic [NW-1:0]      node_q;
	logic [LW-1:0]      lvl_q;
	logic [VW-1:0]      cur_q;
	logic [VW-1:0]      lo_q;
	logic [NW-1:0]      blk_node_q;
	logic [LW-1:0]      blk_lvl_q;
	logic [1:0]         status_q;
	bpa_pkg::rsp_t      out_q;
	logic [NW-1:0]      clr_q;
	logic [VW-1:0]      clr_val_q;
	logic [NW-1:0]      bnd_q;

	logic               wr_en;
	logic [NW-1:0]      wr_addr;
	logic [VW-1:0]      wr_data;
	logic               rd_en;
	logic [NW-1:0]      rd_addr;
	logic [VW-1:0]      rd_data;

	logic [LW-1:0]      ord_lvl;
	logic [VW-1:0]      ord1;
	logic [PW:0]        page_off;
	logic [NW-1:0]      leaf;
	logic [NW-1:0]      left_c;
	logic [NW-1:0]      right_c;
	logic               pick_left;
	logic [NW-1:0]      child;
	logic [NW-1:0]      parent_c;
	logic [VW-1:0]      par_val;
	logic [NW-1:0]      blk_shift;
	logic [POOL_ORDER-1:0] blk_off;
	logic [PW-1:0]      blk_page;

	bpa_ram #(
		.WIDTH (VW),
		.DEPTH (NODES)
	) u_tree (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		ord_lvl  = {1'b0, req_q.alloc_order};
		ord1     = ord_lvl + VW'(1);
		page_off = {1'b0, req_q.page_number} - {1'b0, base_q};
		leaf     = {1'b0, page_off[POOL_ORDER-1:0]} + LEAF_BASE;
		left_c   = {node_q[NW-2:0], 1'b1};
		right_c  = left_c + NW'(1);
		parent_c = (node_q - NW'(1)) >> 1;

		// best fit: smallest child value that still holds the order
		if (bpa_pkg::node_key(lo_q) < ord1) begin
			pick_left = 1'b0;
		end else if (bpa_pkg::node_key(rd_data) < ord1) begin
			pick_left = 1'b1;
		end else begin
			pick_left = bpa_pkg::node_key(lo_q) <= bpa_pkg::node_key(rd_data);
		end
		child = pick_left ? left_c : right_c;

		// merge two wholly free buddies on free, else take the larger
		if (req_q.req_type == bpa_pkg::REQ_FREE && cur_q == lvl_q && rd_data == lvl_q) begin
			par_val = lvl_q + LW'(1);
		end else if (bpa_pkg::node_key(cur_q) >= bpa_pkg::node_key(rd_data)) begin
			par_val = cur_q;
		end else begin
			par_val = rd_data;
		end

		blk_shift = (blk_node_q + NW'(1)) << blk_lvl_q;
		blk_off   = blk_shift[POOL_ORDER-1:0];
		blk_page  = base_q + {{(PW-POOL_ORDER){1'b0}}, blk_off};
	end

	always_comb begin
		st.is_alloc      = req_q.req_type == bpa_pkg::REQ_ALLOC;
		st.is_free       = req_q.req_type == bpa_pkg::REQ_FREE;
		st.in_range      = !page_off[PW] && (page_off[PW-1:POOL_ORDER] == '0);
		st.root_fits     = (ord_lvl <= FULL_LVL) && (bpa_pkg::node_key(rd_data) >= ord1);
		st.at_order      = lvl_q == ord_lvl;
		st.next_at_order = (lvl_q - LW'(1)) == ord_lvl;
		st.node_root     = node_q == '0;
		st.parent_root   = parent_c == '0;
		st.rd_taken      = rd_data == bpa_pkg::NODE_TAKEN;
		st.clear_last    = clr_q == LAST_NODE;
	end

	// tree port steering
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = bpa_pkg::NODE_TAKEN;
		rd_en   = 1'b0;
		rd_addr = node_q;
		unique case (cmd.op)
			bpa_pkg::OP_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = clr_val_q;
			end
			bpa_pkg::OP_BEGIN_ALLOC: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			bpa_pkg::OP_BEGIN_WALK: begin
				rd_en   = 1'b1;
				rd_addr = leaf;
			end
			bpa_pkg::OP_MARK_ROOT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
			end
			bpa_pkg::OP_READ_LEFT: begin
				rd_en   = 1'b1;
				rd_addr = left_c;
			end
			bpa_pkg::OP_READ_RIGHT: begin
				rd_en   = 1'b1;
				rd_addr = right_c;
			end
			bpa_pkg::OP_PICK: begin
				rd_en = 1'b1;
				if (st.next_at_order) begin
					wr_en   = 1'b1;
					wr_addr = child;
					rd_addr = sibling_of(child);
				end else begin
					rd_addr = {child[NW-2:0], 1'b1};
				end
			end
			bpa_pkg::OP_WALK_UP: begin
				rd_en   = 1'b1;
				rd_addr = parent_c;
			end
			bpa_pkg::OP_FOUND: begin
				if (st.is_free) begin
					wr_en   = 1'b1;
					wr_addr = node_q;
					wr_data = lvl_q;
					rd_en   = !st.node_root;
					rd_addr = sibling_of(node_q);
				end
			end
			bpa_pkg::OP_CLIMB: begin
				wr_en   = 1'b1;
				wr_addr = parent_c;
				wr_data = par_val;
				rd_en   = !st.parent_root;
				rd_addr = sibling_of(parent_c);
			end
			default: begin
			end
		endcase
	end

	// config register and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			clr_q     <= '0;
			clr_val_q <= VW'(POOL_ORDER);
			bnd_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (cmd.op == bpa_pkg::OP_CLEAR) begin
				clr_q <= clr_q + NW'(1);
				if (clr_q == bnd_q) begin
					clr_val_q <= clr_val_q - VW'(1);
					bnd_q     <= {bnd_q[NW-2:0], 1'b0} + NW'(2);
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			bpa_pkg::OP_ACCEPT: begin
				req_q    <= in_data;
				status_q <= bpa_pkg::ST_OK;
			end
			bpa_pkg::OP_BEGIN_ALLOC: begin
				node_q <= '0;
				lvl_q  <= FULL_LVL;
			end
			bpa_pkg::OP_BEGIN_WALK: begin
				node_q <= leaf;
				lvl_q  <= '0;
			end
			bpa_pkg::OP_ERR_SPACE: begin
				status_q <= bpa_pkg::ST_NO_SPACE;
			end
			bpa_pkg::OP_ERR_ADDR: begin
				status_q <= bpa_pkg::ST_BAD_ADDR;
			end
			bpa_pkg::OP_MARK_ROOT: begin
				blk_node_q <= '0;
				blk_lvl_q  <= lvl_q;
			end
			bpa_pkg::OP_READ_RIGHT: begin
				lo_q <= rd_data;
			end
			bpa_pkg::OP_PICK: begin
				node_q <= child;
				lvl_q  <= lvl_q - LW'(1);
				if (st.next_at_order) begin
					cur_q      <= bpa_pkg::NODE_TAKEN;
					blk_node_q <= child;
					blk_lvl_q  <= lvl_q - LW'(1);
				end
			end
			bpa_pkg::OP_WALK_UP: begin
				node_q <= parent_c;
				lvl_q  <= lvl_q + LW'(1);
			end
			bpa_pkg::OP_FOUND: begin
				blk_node_q <= node_q;
				blk_lvl_q  <= lvl_q;
				cur_q      <= lvl_q;
			end
			bpa_pkg::OP_CLIMB: begin
				node_q <= parent_c;
				lvl_q  <= lvl_q + LW'(1);
				cur_q  <= par_val;
			end
			bpa_pkg::OP_LOAD_OUT: begin
				out_q.status <= status_q;
				if (status_q == bpa_pkg::ST_OK) begin
					out_q.block_page  <= blk_page;
					out_q.block_order <= blk_lvl_q;
				end else begin
					out_q.block_page  <= '0;
					out_q.block_order <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

>>> rtl/core/bpa_ctrl.sv
`default_nettype none

module bpa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire bpa_pkg::dp_stat_t st,
	output bpa_pkg::dp_cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_ROOT,
		S_RDR,
		S_PICK,
		S_WALK,
		S_UP,
		S_FIN
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   load;

	always_comb begin
		state_d = state_q;
		cmd.op  = bpa_pkg::OP_NONE;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = bpa_pkg::OP_CLEAR;
				if (st.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = bpa_pkg::OP_ACCEPT;
					state_d = S_START;
				end
			end
			S_START: begin
				if (st.is_alloc) begin
					cmd.op  = bpa_pkg::OP_BEGIN_ALLOC;
					state_d = S_ROOT;
				end else if (st.in_range) begin
					cmd.op  = bpa_pkg::OP_BEGIN_WALK;
					state_d = S_WALK;
				end else begin
					cmd.op  = bpa_pkg::OP_ERR_ADDR;
					state_d = S_FIN;
				end
			end
			S_ROOT: begin
				priority if (!st.root_fits) begin
					cmd.op  = bpa_pkg::OP_ERR_SPACE;
					state_d = S_FIN;
				end else if (st.at_order) begin
					cmd.op  = bpa_pkg::OP_MARK_ROOT;
					state_d = S_FIN;
				end else begin
					cmd.op  = bpa_pkg::OP_READ_LEFT;
					state_d = S_RDR;
				end
			end
			S_RDR: begin
				cmd.op  = bpa_pkg::OP_READ_RIGHT;
				state_d = S_PICK;
			end
			S_PICK: begin
				cmd.op  = bpa_pkg::OP_PICK;
				state_d = st.next_at_order ? S_UP : S_RDR;
			end
			S_WALK: begin
				priority if (st.rd_taken) begin
					cmd.op  = bpa_pkg::OP_FOUND;
					state_d = (st.is_free && !st.node_root) ? S_UP : S_FIN;
				end else if (st.node_root) begin
					cmd.op  = bpa_pkg::OP_ERR_ADDR;
					state_d = S_FIN;
				end else begin
					cmd.op = bpa_pkg::OP_WALK_UP;
				end
			end
			S_UP: begin
				cmd.op = bpa_pkg::OP_CLIMB;
				if (st.parent_root) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op  = bpa_pkg::OP_LOAD_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign load = cmd.op == bpa_pkg::OP_LOAD_OUT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> tb/tb_buddy_page_allocator.sv
`default_nettype none

module tb_buddy_page_allocator;

	localparam int POOL_ORDER  = 10;
	localparam int NODE_CNT    = (1 << (POOL_ORDER + 1)) - 1;
	localparam int LEAF_BASE   = (1 << POOL_ORDER) - 1;
	localparam int CYCLE_LIMIT = 1_000_000;

	localparam int PAGE_W  = bpa_pkg::PAGE_W;
	localparam int LEVEL_W = bpa_pkg::LEVEL_W;
	localparam int VAL_W   = bpa_pkg::VAL_W;
	localparam int REQ_W   = bpa_pkg::REQ_W;
	localparam int ORDER_W = bpa_pkg::ORDER_W;

	// one allocated block as the stimulus side tracks it, offset relative to the pool
	typedef struct packed {
		logic [15:0]        off;
		logic [LEVEL_W-1:0] ord;
	} blk_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	bpa_pkg::req_t       in_data;
	logic                out_valid;
	logic                out_stall;
	bpa_pkg::rsp_t       out_data;
	logic                cfg_wr_en;
	logic [PAGE_W-1:0]   cfg_wr_data;

	buddy_page_allocator #(
		.POOL_ORDER(POOL_ORDER)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// tree shadow: each node holds the largest free order below it, taken marker if allocated
	logic [VAL_W-1:0]  tree_val [NODE_CNT];
	logic [PAGE_W-1:0] pool_base;

	bpa_pkg::req_t pending_reqs  [$];
	bpa_pkg::rsp_t expected_rsps [$];
	blk_t          live_blks     [$];

	// handshake bookkeeping for the clocked sender, receiver and monitor processes
	bit item_taken;
	int send_gap;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_left;
	int hold_cycles;

	int cycle_cnt;
	int mismatch_cnt;
	int n_checked;
	int n_alloc, n_free, n_size, n_start;
	int n_ok, n_no_space, n_bad_addr;
	int n_settings;

	// -------------------------------------------------------------------------
	// allocator shadow
	// -------------------------------------------------------------------------

	// node value as a signed order, taken maps to -1
	function automatic int val_int(input logic [VAL_W-1:0] v);
		return (v == bpa_pkg::NODE_TAKEN) ? -1 : int'(v);
	endfunction

	function automatic logic [VAL_W-1:0] larger_val(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		return (val_int(a) > val_int(b)) ? a : b;
	endfunction

	// climb from the page's leaf to the first taken node
	function automatic bit locate_block(input logic [PAGE_W-1:0] page, output int node,
			output int lv);
		int off;
		node = 0;
		lv   = 0;
		if (page < pool_base)
			return 1'b0;
		off = int'(page) - int'(pool_base);
		if (off >= (1 << POOL_ORDER))
			return 1'b0;
		node = off + LEAF_BASE;
		while (tree_val[node] != bpa_pkg::NODE_TAKEN) begin
			// walked past the root without meeting an allocated node
			if (node == 0)
				return 1'b0;
			node = (node - 1) >> 1;
			lv++;
		end
		return 1'b1;
	endfunction

	// expected result for one request, updating the shadow tree as the block would
	function automatic bpa_pkg::rsp_t predict_rsp(input bpa_pkg::req_t r);
		bpa_pkg::rsp_t res;
		int   ord, node, lv, lo, ro, off, i;
		res  = '0;
		ord  = int'(r.alloc_order);
		node = 0;
		if (r.req_type == bpa_pkg::REQ_ALLOC) begin
			// order beyond the pool or beyond the largest free block
			if (ord > POOL_ORDER || val_int(tree_val[0]) < ord) begin
				res.status = bpa_pkg::ST_NO_SPACE;
				return res;
			end
			// best-fit descent: smallest child value that still fits
			for (lv = POOL_ORDER; lv != ord; lv--) begin
				lo = val_int(tree_val[2 * node + 1]);
				ro = val_int(tree_val[2 * node + 2]);
				if (lo < ord)
					node = 2 * node + 2;
				else if (ro < ord)
					node = 2 * node + 1;
				else
					node = (lo <= ro) ? 2 * node + 1 : 2 * node + 2;
			end
			tree_val[node] = bpa_pkg::NODE_TAKEN;
			off = ((node + 1) << ord) - (1 << POOL_ORDER);
			res.status      = bpa_pkg::ST_OK;
			res.block_page  = PAGE_W'(int'(pool_base) + off);
			res.block_order = LEVEL_W'(ord);
			live_blks.push_back('{off: 16'(off), ord: LEVEL_W'(ord)});
			while (node != 0) begin
				node = (node - 1) >> 1;
				tree_val[node] = larger_val(tree_val[2 * node + 1], tree_val[2 * node + 2]);
			end
			return res;
		end

		if (!locate_block(r.page_number, node, lv)) begin
			res.status = bpa_pkg::ST_BAD_ADDR;
			return res;
		end
		off = ((node + 1) << lv) - (1 << POOL_ORDER);
		res.status      = bpa_pkg::ST_OK;
		res.block_page  = PAGE_W'(int'(pool_base) + off);
		res.block_order = LEVEL_W'(lv);

		if (r.req_type == bpa_pkg::REQ_FREE) begin
			tree_val[node] = VAL_W'(lv);
			// merge upward only where both children are wholly free
			while (node != 0) begin
				node = (node - 1) >> 1;
				lv++;
				lo = val_int(tree_val[2 * node + 1]);
				ro = val_int(tree_val[2 * node + 2]);
				if (lo == lv - 1 && ro == lv - 1)
					tree_val[node] = VAL_W'(lv);
				else
					tree_val[node] = larger_val(tree_val[2 * node + 1], tree_val[2 * node + 2]);
			end
			for (i = 0; i < live_blks.size(); i++) begin
				if (int'(live_blks[i].off) == off) begin
					live_blks.delete(i);
					break;
				end
			end
		end
		return res;
	endfunction

	// -------------------------------------------------------------------------
	// stimulus helpers
	// -------------------------------------------------------------------------

	function automatic bpa_pkg::req_t mk_req(input logic [REQ_W-1:0] t,
			input logic [ORDER_W-1:0] o, input logic [PAGE_W-1:0] p);
		bpa_pkg::req_t r;
		r.req_type    = t;
		r.alloc_order = o;
		r.page_number = p;
		return r;
	endfunction

	// idle length: zero most of the time at low pct, mostly short, now and then long
	function automatic int idle_len(input int pct);
		int k;
		if ($urandom_range(0, 99) >= pct)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 75)
			return $urandom_range(1, 3);
		if (k < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// mostly well-formed traffic against live blocks, some noise and broken addresses
	function automatic bpa_pkg::req_t make_request();
		bpa_pkg::req_t r;
		blk_t b;
		int   pick, k, alloc_pct;
		r.req_type    = bpa_pkg::REQ_ALLOC;
		r.alloc_order = ORDER_W'($urandom_range(0, 15));
		r.page_number = PAGE_W'($urandom);
		pick = $urandom_range(0, 99);
		// raw noise: every field fully random
		if (pick < 5) begin
			r.req_type = REQ_W'($urandom_range(0, 3));
			return r;
		end
		alloc_pct = (live_blks.size() > 24) ? 25 : 50;
		if (live_blks.size() == 0 || pick < alloc_pct) begin
			k = $urandom_range(0, 99);
			if (k < 70)
				r.alloc_order = ORDER_W'($urandom_range(0, 3));
			else if (k < 95)
				r.alloc_order = ORDER_W'($urandom_range(4, POOL_ORDER));
			else
				r.alloc_order = ORDER_W'($urandom_range(POOL_ORDER + 1, 15));
			return r;
		end
		b = live_blks[$urandom_range(0, live_blks.size() - 1)];
		k = $urandom_range(0, 99);
		if (k < 60)
			r.req_type = bpa_pkg::REQ_FREE;
		else if (k < 80)
			r.req_type = bpa_pkg::REQ_SIZE;
		else
			r.req_type = bpa_pkg::REQ_START;
		// any page inside the block finds it
		r.page_number = PAGE_W'(int'(pool_base) + int'(b.off) +
			$urandom_range(0, (1 << b.ord) - 1));
		// a few addresses just off either end of the pool
		k = $urandom_range(0, 19);
		if (k == 0)
			r.page_number = PAGE_W'(int'(pool_base) + (1 << POOL_ORDER) + $urandom_range(0, 64));
		else if (k == 1)
			r.page_number = PAGE_W'(int'(pool_base) - 1 - $urandom_range(0, 64));
		return r;
	endfunction

	// wait until every item is sent and every result has come back
	task automatic drain_all();
		do begin
			@(posedge clk);
			#1;
		end while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0);
	endtask

	task automatic set_pool_base(input logic [PAGE_W-1:0] v);
		// give any trailing tree update in the block time to settle
		repeat (40) @(posedge clk);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		pool_base = v;
		n_settings++;
	endtask

	// random phase; items generated one at a time so they track the live blocks
	task automatic run_phase(input int n_items, input int send_pct, input int recv_pct,
			input int hold_at);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < n_items; i++) begin
			while (pending_reqs.size() != 0)
				@(posedge clk);
			if (i == hold_at)
				hold_cycles = 500;
			pending_reqs.push_back(make_request());
		end
		drain_all();
	endtask

	function automatic void log_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%s", msg);
	endfunction

	// -------------------------------------------------------------------------
	// clock, driver, receiver, monitor
	// -------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sender: drives on the falling edge, holds a stalled item steady
	always @(negedge clk) begin
		if (in_valid && !item_taken) begin
			// still waiting for the block to take it
		end else begin
			item_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				in_data  <= pending_reqs.pop_front();
				in_valid <= 1'b1;
				send_gap = idle_len(send_idle_pct);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stall runs, plus a long hold-off on request to back the block up
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			stall_left  = hold_cycles;
			hold_cycles = 0;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			stall_left = idle_len(recv_idle_pct);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// monitor: predicts on every accepted item and checks every accepted result
	always @(posedge clk) begin : monitor
		bpa_pkg::rsp_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_rsps.push_back(predict_rsp(in_data));
				item_taken = 1'b1;
				case (in_data.req_type)
					bpa_pkg::REQ_ALLOC: n_alloc++;
					bpa_pkg::REQ_FREE:  n_free++;
					bpa_pkg::REQ_SIZE:  n_size++;
					default:            n_start++;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_rsps.size() == 0) begin
					log_mismatch($sformatf("result with nothing expected: status %0d page %0h order %0d",
						out_data.status, out_data.block_page, out_data.block_order));
				end else begin
					want = expected_rsps.pop_front();
					n_checked++;
					case (want.status)
						bpa_pkg::ST_OK:       n_ok++;
						bpa_pkg::ST_NO_SPACE: n_no_space++;
						default:              n_bad_addr++;
					endcase
					if (out_data.status !== want.status ||
							out_data.block_page !== want.block_page ||
							out_data.block_order !== want.block_order)
						log_mismatch($sformatf(
							"result %0d: status exp %0d got %0d, page exp %0h got %0h, order exp %0d got %0d",
							n_checked, want.status, out_data.status, want.block_page,
							out_data.block_page, want.block_order, out_data.block_order));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				expected_rsps.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// -------------------------------------------------------------------------
	// test sequence
	// -------------------------------------------------------------------------

	initial begin
		int lvl;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		out_stall     = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		item_taken    = 1'b0;
		send_gap      = 0;
		stall_left    = 0;
		hold_cycles   = 0;
		send_idle_pct = 20;
		recv_idle_pct = 20;
		pool_base     = '0;

		// whole pool free: a node at depth d holds POOL_ORDER - d
		lvl = POOL_ORDER + 1;
		for (int i = 0; i < NODE_CNT; i++) begin
			if (((i + 1) & i) == 0)
				lvl--;
			tree_val[i] = VAL_W'(lvl);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: order limits, whole-pool block, range checks, split and merge
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_ALLOC, 4'd15, '0));        // order above pool
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_ALLOC, 4'd11, '0));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_ALLOC, 4'd10, 20'hFFFFF)); // whole pool
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_ALLOC, 4'd0, '0));         // nothing left
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_SIZE, 4'd0, 20'd1023));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_START, 4'd15, 20'd0));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_SIZE, 4'd0, 20'd1024));    // first page past pool
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_START, 4'd0, 20'hFFFFF));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_FREE, 4'd0, 20'd517));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_FREE, 4'd0, 20'd517));     // double free
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_SIZE, 4'd0, 20'd3));       // nothing allocated
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_ALLOC, 4'd0, '0));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_ALLOC, 4'd0, '0));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_ALLOC, 4'd1, '0));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_ALLOC, 4'd9, '0));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_ALLOC, 4'd9, '0));         // exceeds root value
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_START, 4'd0, 20'd1));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_SIZE, 4'd0, 20'd3));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_FREE, 4'd0, 20'd1));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_FREE, 4'd0, 20'd0));       // buddies merge
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_FREE, 4'd0, 20'd3));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_ALLOC, 4'd10, '0));        // right half taken
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_FREE, 4'd0, 20'd700));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_ALLOC, 4'd10, '0));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_FREE, 4'd0, 20'd0));
		drain_all();

		run_phase(300, 30, 30, -1);

		// pool at the very top of page space: starts wrap, low pages fall below the pool
		set_pool_base(20'hFFFFF);
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_SIZE, 4'd0, 20'd0));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_ALLOC, 4'd0, '0));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_ALLOC, 4'd0, '0));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_FREE, 4'd0, 20'd0));
		pending_reqs.push_back(mk_req(bpa_pkg::REQ_FREE, 4'd0, 20'hFFFFF));
		drain_all();
		// long receiver hold-off partway in
		run_phase(300, 50, 20, 100);

		// no idling on either side
		set_pool_base(20'h5A5A5);
		run_phase(250, 0, 0, -1);

		// pool exactly filling the top of page space, heavy idling
		set_pool_base(20'hFFC00);
		run_phase(250, 70, 60, -1);

		set_pool_base(20'h00000);
		run_phase(300, 30, 40, 150);

		repeat (50) @(posedge clk);
		if (expected_rsps.size() != 0)
			log_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));

		$display("run covered %0d requests (%0d allocate, %0d free, %0d size, %0d start) over %0d base settings",
			n_alloc + n_free + n_size + n_start, n_alloc, n_free, n_size, n_start,
			n_settings + 1);
		$display("checked %0d results (%0d ok, %0d no space, %0d bad address), %0d mismatches",
			n_checked, n_ok, n_no_space, n_bad_addr, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/bpa_datapath.sv
rtl/core/bpa_ctrl.sv
rtl/core/buddy_page_allocator.sv
tb/tb_buddy_page_allocator.sv
